[hdl/l3ci_pkg.sv]
// ----------------------------------------------------------------------------
// l3ci_pkg
// Shared types, constants and helpers for the 3D colour cube interpolator.
// ----------------------------------------------------------------------------
package l3ci_pkg;

	localparam int MAX_GRID_DEF = 17;
	localparam int PIX_W        = 16;
	localparam int IDX_W        = 5;
	localparam int NODE_IDX_W   = 13;
	localparam int POS_W        = PIX_W + IDX_W;
	localparam int IN_DATA_W    = 112;
	localparam int OUT_DATA_W   = 48;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [PIX_W-1:0]      FULL_SCALE  = 16'hFFFF;
	localparam logic [POS_W-1:0]      HALF_SCALE  = 21'd32767;
	localparam logic [IDX_W-1:0]      GRID_RESET  = 5'd17;
	localparam logic [CFG_DATA_W-1:0] PREC_8      = 5'd8;
	localparam logic [CFG_DATA_W-1:0] PREC_16     = 5'd16;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_TRILINEAR   = 2'd0,
		MODE_TETRAHEDRAL = 2'd1,
		MODE_NEAREST     = 2'd2,
		MODE_UNSUPPORTED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CFG  = 2'd1,
		ST_BAD_MODE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_GRID = 2'd1,
		REG_PREC = 2'd2
	} reg_idx_t;

	typedef struct packed {
		mode_t                 mode;
		logic [IDX_W-1:0]      grid;
		logic [CFG_DATA_W-1:0] prec;
	} cfg_t;

	typedef struct packed {
		op_t                         op;
		status_t                     status;
		logic [2:0][IDX_W-1:0]       lo;
		logic [2:0][IDX_W-1:0]       hi;
		logic [2:0][PIX_W-1:0]       frac;
		logic [NODE_IDX_W-1:0]       node_index;
		logic [2:0][PIX_W-1:0]       node_val;
	} cmd_t;

	typedef struct packed {
		op_t                   op;
		status_t               status;
		logic [2:0][PIX_W-1:0] frac;
	} side_t;

	// Quotient by 65535 for dividends below 65535 * 65536.
	function automatic logic [PIX_W-1:0] div_full(input logic [31:0] x);
		logic [31:0] t;
		t = x + {16'd0, x[31:16]} + 32'd1;
		return t[31:16];
	endfunction

endpackage

[hdl/l3ci_lerp.sv]
// ----------------------------------------------------------------------------
// l3ci_lerp
// Three-stage blend of two 16-bit values by a weight over 65535, truncated.
// ----------------------------------------------------------------------------
module l3ci_lerp (
	input  logic                        clk,
	input  logic                        en,
	input  logic [l3ci_pkg::PIX_W-1:0]  a,
	input  logic [l3ci_pkg::PIX_W-1:0]  b,
	input  logic [l3ci_pkg::PIX_W-1:0]  f,
	output logic [l3ci_pkg::PIX_W-1:0]  y
);
	import l3ci_pkg::*;

	logic [31:0] pa_s1, pb_s1, sum_s2;
	logic [PIX_W-1:0] y_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= 32'(a) * 32'(FULL_SCALE - f);
			pb_s1  <= 32'(b) * 32'(f);
			sum_s2 <= pa_s1 + pb_s1;
			y_s3   <= div_full(sum_s2);
		end
	end

	assign y = y_s3;

endmodule

[hdl/l3ci_queue.sv]
// ----------------------------------------------------------------------------
// l3ci_queue
// Short command queue between the classifying front and the datapath back.
// ----------------------------------------------------------------------------
module l3ci_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  l3ci_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output l3ci_pkg::cmd_t rdata,
	output logic           empty
);
	import l3ci_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

[hdl/l3ci_front.sv]
// ----------------------------------------------------------------------------
// l3ci_front
// Accepts words, checks the configuration and finds grid cell and weights.
// ----------------------------------------------------------------------------
module l3ci_front #(
	parameter int MaxGrid = l3ci_pkg::MAX_GRID_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  l3ci_pkg::op_t                         in_op,
	input  logic [l3ci_pkg::NODE_IDX_W-1:0]       node_index,
	input  logic [2:0][l3ci_pkg::PIX_W-1:0]       node_val,
	input  logic [2:0][l3ci_pkg::PIX_W-1:0]       color,
	input  l3ci_pkg::cfg_t                        cfg,
	input  logic                                  q_full,
	output logic                                  q_push,
	output l3ci_pkg::cmd_t                        q_cmd
);
	import l3ci_pkg::*;

	logic                  v_s1, v_s2, v_s3, en;
	cmd_t                  cmd_s1, cmd_s2, cmd_s3, cmd_n;
	logic [2:0][PIX_W-1:0] color_s1;
	logic [2:0][POS_W-1:0] p_s2;
	logic                  bad_cfg;
	status_t               status_in;
	logic [IDX_W-1:0]      gm1;

	assign en       = !(v_s3 && q_full);
	assign in_ready = en;
	assign q_push   = v_s3 && !q_full;
	assign q_cmd    = cmd_s3;
	assign gm1      = cfg.grid - 1'b1;

	// A bad grid size or precision takes priority over a bad mode.
	assign bad_cfg = (cfg.grid == '0) || (int'(cfg.grid) > MaxGrid) ||
			((cfg.prec != PREC_8) && (cfg.prec != PREC_16));
	assign status_in = bad_cfg ? ST_BAD_CFG :
			(cfg.mode == MODE_UNSUPPORTED) ? ST_BAD_MODE : ST_OK;

	always_comb begin
		logic [PIX_W-1:0] q, r;
		logic [IDX_W:0]   nxt;
		q     = '0;
		r     = '0;
		nxt   = '0;
		cmd_n = cmd_s2;
		for (int k = 0; k < 3; k++) begin
			if (cfg.mode == MODE_NEAREST) begin
				// Rounds half up; the result is clamped to the last node.
				q = div_full(32'(p_s2[k] + HALF_SCALE));
				cmd_n.lo[k]   = (q > PIX_W'(gm1)) ? gm1 : q[IDX_W-1:0];
				cmd_n.hi[k]   = cmd_n.lo[k];
				cmd_n.frac[k] = '0;
			end else begin
				q = div_full(32'(p_s2[k]));
				r = p_s2[k][PIX_W-1:0] + q;
				nxt = {1'b0, q[IDX_W-1:0]} + 1'b1;
				cmd_n.lo[k]   = q[IDX_W-1:0];
				cmd_n.hi[k]   = (nxt >= {1'b0, cfg.grid}) ? q[IDX_W-1:0] : nxt[IDX_W-1:0];
				cmd_n.frac[k] = r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= '{op: in_op, status: status_in, lo: '0, hi: '0, frac: '0,
					node_index: node_index, node_val: node_val};
			color_s1 <= color;
			cmd_s2   <= cmd_s1;
			for (int k = 0; k < 3; k++) p_s2[k] <= POS_W'(color_s1[k]) * POS_W'(gm1);
			cmd_s3   <= cmd_n;
		end
	end

endmodule

[hdl/l3ci_back.sv]
// ----------------------------------------------------------------------------
// l3ci_back
// Node addressing, node memory and the three-level blend, with output word.
// ----------------------------------------------------------------------------
module l3ci_back #(
	parameter int MaxGrid = l3ci_pkg::MAX_GRID_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  l3ci_pkg::cfg_t                   cfg,
	input  logic                             q_empty,
	output logic                             q_pop,
	input  l3ci_pkg::cmd_t                   q_cmd,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0][l3ci_pkg::PIX_W-1:0]  out_val,
	output l3ci_pkg::status_t                out_status
);
	import l3ci_pkg::*;

	localparam int Depth = MaxGrid * MaxGrid * MaxGrid;
	localparam int AW    = $clog2(Depth);
	localparam int NS    = 13;

	logic                  en, p8;
	logic [NS:1]           v_s;
	side_t                 side_s [1:NS];
	cmd_t                  cmd_s1, cmd_s2, cmd_s3;
	logic [1:0][AW-1:0]    row_s1;
	logic [3:0][AW-1:0]    plane_s2;
	logic [7:0][AW-1:0]    addr_s3;
	logic                  wr_s3;
	logic [7:0][47:0]      corner;
	logic [2:0][3:0][PIX_W-1:0] y1;
	logic [2:0][1:0][PIX_W-1:0] y2;
	logic [2:0][PIX_W-1:0] y3;
	logic                  out_valid_q;
	logic [2:0][PIX_W-1:0] out_val_q;
	status_t               out_status_q;

	assign en         = !out_valid_q || out_ready;
	assign q_pop      = en && !q_empty;
	assign p8         = (cfg.prec == PREC_8);
	assign out_valid  = out_valid_q;
	assign out_val    = out_val_q;
	assign out_status = out_status_q;

	// 8-bit nodes are widened by repeating the byte, i.e. value * 257.
	function automatic logic [PIX_W-1:0] chan(input logic [47:0] w, input int ch,
			input logic narrow);
		logic [PIX_W-1:0] v;
		v = w[ch*PIX_W +: PIX_W];
		return narrow ? {v[7:0], v[7:0]} : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s         <= {v_s[NS-1:1], !q_empty};
			out_valid_q <= v_s[NS] && (side_s[NS].op == OP_XFORM);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1    <= q_cmd;
			side_s[1] <= '{op: q_cmd.op, status: q_cmd.status, frac: q_cmd.frac};
			for (int i = 2; i <= NS; i++) side_s[i] <= side_s[i-1];
			for (int r = 0; r < 2; r++)
				row_s1[r] <= AW'(r[0] ? q_cmd.hi[0] : q_cmd.lo[0]) * AW'(cfg.grid);
			cmd_s2 <= cmd_s1;
			for (int j = 0; j < 4; j++)
				plane_s2[j] <= (row_s1[j/2] +
						AW'(j[0] ? cmd_s1.hi[1] : cmd_s1.lo[1])) * AW'(cfg.grid);
			cmd_s3 <= cmd_s2;
			for (int c = 0; c < 8; c++)
				addr_s3[c] <= plane_s2[c/2] + AW'(c[0] ? cmd_s2.hi[2] : cmd_s2.lo[2]);
			wr_s3 <= (cmd_s2.op == OP_LOAD) && (int'(cmd_s2.node_index) < Depth);
			out_val_q    <= (side_s[NS].status == ST_OK) ? y3 : '0;
			out_status_q <= side_s[NS].status;
		end
	end

	// Four copies of the node memory, each read at the two blue corners of
	// one red/green pair; a load writes every copy.
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [47:0]        mem [Depth];
		logic [1:0][47:0]   rd_s4;
		always_ff @(posedge clk) begin
			if (en && v_s[3] && wr_s3) mem[AW'(cmd_s3.node_index)] <= cmd_s3.node_val;
			if (en) begin
				rd_s4[0] <= mem[addr_s3[2*k]];
				rd_s4[1] <= mem[addr_s3[2*k+1]];
			end
		end
		assign corner[2*k]   = rd_s4[0];
		assign corner[2*k+1] = rd_s4[1];
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		for (genvar j = 0; j < 4; j++) begin : g_blue
			l3ci_lerp u_lerp (
				.clk (clk),
				.en  (en),
				.a   (chan(corner[2*j], ch, p8)),
				.b   (chan(corner[2*j+1], ch, p8)),
				.f   (side_s[4].frac[2]),
				.y   (y1[ch][j])
			);
		end
		for (genvar r = 0; r < 2; r++) begin : g_green
			l3ci_lerp u_lerp (
				.clk (clk),
				.en  (en),
				.a   (y1[ch][2*r]),
				.b   (y1[ch][2*r+1]),
				.f   (side_s[7].frac[1]),
				.y   (y2[ch][r])
			);
		end
		l3ci_lerp u_red (
			.clk (clk),
			.en  (en),
			.a   (y2[ch][0]),
			.b   (y2[ch][1]),
			.f   (side_s[10].frac[0]),
			.y   (y3[ch])
		);
	end

endmodule

[hdl/lut3d_color_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// lut3d_color_interpolator_unit
// Maps 16-bit RGB colours through a loaded 3D node cube, trilinear or nearest.
// ----------------------------------------------------------------------------
// An accepted colour word reaches its result word through 3 front stages,
// 1 in the queue and 14 in the back datapath.
// Throughput: one word per cycle while the receiver is ready, set by the
// four double-read node memories. Loads give no result. Reset clears all
// control state and restores the registers to trilinear, 17 nodes per axis,
// 16-bit nodes; node memory is not cleared and holds no meaning until loaded.
module lut3d_color_interpolator_unit #(
	parameter int MaxGrid = l3ci_pkg::MAX_GRID_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// node_index, node_red, node_green, node_blue, color_red, color_green,
	// color_blue, then zero padding
	input  logic [l3ci_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// operation
	input  logic [0:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_red, out_green, out_blue
	output logic [l3ci_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status
	output logic [1:0]                           m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic [l3ci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [l3ci_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import l3ci_pkg::*;

	cfg_t                  cfg_q;
	logic                  q_push, q_pop, q_full, q_empty;
	cmd_t                  q_wcmd, q_rcmd;
	logic [2:0][PIX_W-1:0] node_val, color, out_val;
	status_t               out_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_TRILINEAR;
			cfg_q.grid <= GRID_RESET;
			cfg_q.prec <= PREC_16;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE: cfg_q.mode <= mode_t'(cfg_data[1:0]);
				REG_GRID: cfg_q.grid <= cfg_data;
				REG_PREC: cfg_q.prec <= cfg_data;
				default: ;
			endcase
		end
	end

	assign node_val[0] = s_axis_tdata[28:13];
	assign node_val[1] = s_axis_tdata[44:29];
	assign node_val[2] = s_axis_tdata[60:45];
	assign color[0]    = s_axis_tdata[76:61];
	assign color[1]    = s_axis_tdata[92:77];
	assign color[2]    = s_axis_tdata[108:93];

	l3ci_front #(.MaxGrid(MaxGrid)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (op_t'(s_axis_tuser[0])),
		.node_index (s_axis_tdata[NODE_IDX_W-1:0]),
		.node_val   (node_val),
		.color      (color),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_wcmd)
	);

	l3ci_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wcmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rcmd),
		.empty  (q_empty)
	);

	l3ci_back #(.MaxGrid(MaxGrid)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_cmd      (q_rcmd),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_val    (out_val),
		.out_status (out_status)
	);

	assign m_axis_tdata = {out_val[2], out_val[1], out_val[0]};
	assign m_axis_tuser = out_status;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("command queue read while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_full) else $error("input stalled with queue space free");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
		else $error("error result carries a non-zero colour");

endmodule

[bench/lut3d_checker.sv]
// ----------------------------------------------------------------------------
// lut3d_checker
// Watches both streams of the colour cube interpolator, keeps its own copy of
// the node cube and registers, predicts each result word and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lut3d_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [l3ci_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [l3ci_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [1:0]                      m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [l3ci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [l3ci_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);
	import l3ci_pkg::*;

	localparam int DEPTH = MAX_GRID_DEF * MAX_GRID_DEF * MAX_GRID_DEF;

	typedef struct packed {
		status_t     status;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} colour_res_t;

	logic [47:0] cube[DEPTH];
	mode_t       cur_mode;
	logic [4:0]  cur_grid;
	logic [4:0]  cur_prec;
	colour_res_t expected_colours[$];

	assign pending = expected_colours.size();

	function automatic logic [15:0] node_value(int r, int g, int b, int ch);
		int unsigned addr;
		logic [15:0] v;
		addr = (r * cur_grid + g) * cur_grid + b;
		if (addr >= DEPTH)
			return 16'd0;
		v = cube[addr][16*ch +: 16];
		if (cur_prec == PREC_8)
			v = v[7:0] * 16'd257;
		return v;
	endfunction

	function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, int unsigned f);
		longint unsigned s;
		s = longint'(a) * (65535 - f) + longint'(b) * f;
		return 16'(s / 65535);
	endfunction

	function automatic colour_res_t map_colour(logic [47:0] rgb);
		colour_res_t res;
		int unsigned gm1, p, i;
		int unsigned lo[3], hi[3], fr[3];
		logic [15:0] c00, c01, c10, c11, c0, c1;
		res = '0;
		if (cur_grid == 0 || cur_grid > MAX_GRID_DEF ||
				(cur_prec != PREC_8 && cur_prec != PREC_16)) begin
			res.status = ST_BAD_CFG;
			return res;
		end
		if (cur_mode == MODE_UNSUPPORTED) begin
			res.status = ST_BAD_MODE;
			return res;
		end
		res.status = ST_OK;
		gm1 = cur_grid - 1;
		for (int k = 0; k < 3; k++) begin
			p = rgb[16*k +: 16] * gm1;
			if (cur_mode == MODE_NEAREST) begin
				i = (2 * p + 65535) / (2 * 65535);
				lo[k] = (i > gm1) ? gm1 : i;
			end else begin
				lo[k] = p / 65535;
				fr[k] = p % 65535;
				hi[k] = (lo[k] + 1 >= cur_grid) ? lo[k] : lo[k] + 1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (cur_mode == MODE_NEAREST) begin
				c0 = node_value(lo[0], lo[1], lo[2], k);
			end else begin
				c00 = blend(node_value(lo[0], lo[1], lo[2], k),
					node_value(lo[0], lo[1], hi[2], k), fr[2]);
				c01 = blend(node_value(lo[0], hi[1], lo[2], k),
					node_value(lo[0], hi[1], hi[2], k), fr[2]);
				c10 = blend(node_value(hi[0], lo[1], lo[2], k),
					node_value(hi[0], lo[1], hi[2], k), fr[2]);
				c11 = blend(node_value(hi[0], hi[1], lo[2], k),
					node_value(hi[0], hi[1], hi[2], k), fr[2]);
				c0 = blend(blend(c00, c01, fr[1]), blend(c10, c11, fr[1]), fr[0]);
			end
			case (k)
				0: res.red = c0;
				1: res.green = c0;
				default: res.blue = c0;
			endcase
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		colour_res_t got, want;
		if (!arst_n) begin
			cur_mode = MODE_TRILINEAR;
			cur_grid = GRID_RESET;
			cur_prec = PREC_16;
			errors = 0;
			expected_colours.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: cur_mode = mode_t'(cfg_data[1:0]);
					REG_GRID: cur_grid = cfg_data;
					REG_PREC: cur_prec = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (op_t'(s_axis_tuser) == OP_LOAD) begin
					if (s_axis_tdata[12:0] < DEPTH)
						cube[s_axis_tdata[12:0]] = s_axis_tdata[60:13];
				end else begin
					expected_colours.push_back(map_colour(s_axis_tdata[108:61]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = {status_t'(m_axis_tuser), m_axis_tdata};
				if (expected_colours.size() == 0) begin
					$error("unexpected result word %h", got);
					errors++;
				end else begin
					want = expected_colours.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errors++;
					end
					if (got.red != want.red) begin
						$error("out_red: expected %h, actual %h", want.red, got.red);
						errors++;
					end
					if (got.green != want.green) begin
						$error("out_green: expected %h, actual %h", want.green, got.green);
						errors++;
					end
					if (got.blue != want.blue) begin
						$error("out_blue: expected %h, actual %h", want.blue, got.blue);
						errors++;
					end
				end
			end
		end
	end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Loads node cubes, then streams colours through the interpolator under
// several register settings and idling patterns; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import l3ci_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    pending;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;

	always #5 clk = ~clk;

	lut3d_color_interpolator_unit DUT (.*);
	lut3d_checker checker_i (.*);

	// Receiver stalls at random according to the current phase.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// The valid line is left high after acceptance; the next word, an idle
	// cycle or a drain takes it over at the same edge.
	task automatic send_word(op_t op, logic [12:0] idx, logic [47:0] node,
			logic [47:0] colour);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b0, colour, node, idx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [4:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic setup(mode_t mode, logic [4:0] grid, logic [4:0] prec);
		drain();
		write_reg(REG_MODE, 5'(mode));
		write_reg(REG_GRID, grid);
		write_reg(REG_PREC, prec);
		cfg_we <= 1'b0;
	endtask

	// Every node of the whole store gets a value so no read is undefined.
	task automatic load_cube();
		for (int i = 0; i < 4913; i++)
			send_word(OP_LOAD, 13'(i), {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(32767 + $urandom_range(2));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic colours(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_word(OP_LOAD, 13'($urandom_range(4912)), {$urandom, $urandom},
					{$urandom, $urandom});
			else
				send_word(OP_XFORM, 13'($urandom), {$urandom, $urandom},
					{rand_chan(), rand_chan(), rand_chan()});
		end
	endtask

	initial begin
		#200000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		mode_t modes[4] = '{MODE_TRILINEAR, MODE_TETRAHEDRAL, MODE_NEAREST,
			MODE_UNSUPPORTED};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_cube();
		// Directed: extremes and ignored out-of-range loads.
		send_word(OP_LOAD, 13'h1FFF, 48'hFFFF_FFFF_FFFF, '0);
		send_word(OP_LOAD, 13'd4913, '0, '0);
		send_word(OP_XFORM, '0, '0, 48'h0);
		send_word(OP_XFORM, '1, '1, 48'hFFFF_FFFF_FFFF);
		send_word(OP_XFORM, '0, '0, 48'h8000_7FFF_8000);
		foreach (modes[m]) begin
			setup(modes[m], 5'd17, PREC_16);
			send_word(OP_XFORM, '0, '0, 48'h0001_FFFE_7FFF);
			send_word(OP_XFORM, '0, '0, {$urandom, $urandom});
		end
		setup(MODE_TRILINEAR, 5'd0, PREC_16);
		send_word(OP_XFORM, '0, '0, 48'h1234_5678_9ABC);
		setup(MODE_TRILINEAR, 5'd31, PREC_16);
		send_word(OP_XFORM, '0, '0, 48'h1234_5678_9ABC);
		setup(MODE_UNSUPPORTED, 5'd17, 5'd31);
		send_word(OP_XFORM, '0, '0, 48'h1234_5678_9ABC);
		setup(MODE_NEAREST, 5'd1, PREC_8);
		send_word(OP_XFORM, '0, '0, 48'hFFFF_FFFF_FFFF);

		// Random phases under varied settings and idling.
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			case (ph)
				0: setup(MODE_TRILINEAR, 5'd17, PREC_16);
				1: setup(MODE_NEAREST, 5'd17, PREC_8);
				2: setup(MODE_TETRAHEDRAL, 5'd2, PREC_16);
				3: setup(MODE_TRILINEAR, 5'd1, PREC_8);
				4: setup(MODE_NEAREST, 5'd2, PREC_16);
				5: setup(MODE_TRILINEAR, 5'd0, PREC_8);
				6: setup(MODE_UNSUPPORTED, 5'd9, PREC_16);
				7: setup(MODE_TRILINEAR, 5'd17, 5'd0);
				default: setup(modes[$urandom_range(3)], 5'($urandom_range(1, 17)),
					$urandom_range(1) ? PREC_8 : PREC_16);
			endcase
			colours(ph < 8 ? 80 : 180);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/l3ci_pkg.sv
hdl/l3ci_lerp.sv
hdl/l3ci_queue.sv
hdl/l3ci_front.sv
hdl/l3ci_back.sv
hdl/lut3d_color_interpolator_unit.sv
bench/lut3d_checker.sv
bench/testbench.sv
